// ===== design/circular_orbit_position_update_assert.svh =====
// ----------------------------------------------------------------------------
// circular orbit position update: assertion macros
// concurrent checks that can be compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_ORBIT_POSITION_UPDATE_ASSERT_SVH
`define CIRCULAR_ORBIT_POSITION_UPDATE_ASSERT_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define COUP_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define COUP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define COUP_ASSERT_SAME(name, clk, rst_n, ante, cons, msg)
`define COUP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/coup_pkg.sv =====
// ----------------------------------------------------------------------------
// circular orbit position update: package
// field widths, command and status types, cordic constant builders
// ----------------------------------------------------------------------------
`default_nettype none

package coup_pkg;

  // field widths
  localparam int ID_W     = 4;
  localparam int RADIUS_W = 47;
  localparam int RATE_W   = 40;
  localparam int START_W  = 32;
  localparam int TIME_W   = 48;
  localparam int POS_W    = 48;

  localparam int NUM_BODIES_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 32;

  localparam logic [POS_W-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [POS_W-1:0] POS_MIN = 48'h8000_0000_0000;

  // products run through the shared multiplier, in issue order
  typedef enum logic [3:0] {
    MOP_PHASE,
    MOP_ANGLE,
    MOP_POSX,
    MOP_POSY,
    MOP_OMEGA,
    MOP_WX,
    MOP_VX,
    MOP_WY,
    MOP_VY
  } mul_op_e;

  typedef struct packed {
    logic    accept;
    logic    load;
    logic    mul_start;
    logic    capture;
    logic    rot_step;
    logic    finish;
    mul_op_e op;
  } coup_cmd_t;

  typedef struct packed {
    logic radius_zero;
    logic mul_done;
    logic rot_last;
  } coup_sts_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  // restoring division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  // arctan(1/n) in q61
  function automatic logic [63:0] acot_q61(input logic [63:0] n);
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] nn;
    nn  = n * n;
    t   = udiv64(64'd1 << 61, n);
    sum = '0;
    for (int k = 0; k < 40; k++) begin
      if (t != '0) begin
        term = udiv64(t, 64'(2 * k + 1));
        if (k % 2 == 0) sum = sum + term;
        else sum = sum - term;
        t = udiv64(t, nn);
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] pi_quarter_q61();
    return (64'd4 * acot_q61(64'd5)) - acot_q61(64'd239);
  endfunction

  // arctan(2^-i) in q61, pi/4 for the first step
  function automatic logic [63:0] atan_q61(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int sh;
    sum = '0;
    if (i == 0) return pi_quarter_q61();
    for (int k = 0; k < 32; k++) begin
      sh = i * (2 * k + 1);
      if (sh <= 61) begin
        term = udiv64(64'd1 << (61 - sh), 64'(2 * k + 1));
        if (k % 2 == 0) sum = sum + term;
        else sum = sum - term;
      end
    end
    return sum;
  endfunction

  // rounded product shifted down, clamped to 64 bits
  function automatic logic [63:0] mulshr_c(input logic [63:0] a, input logic [63:0] b,
                                           input int s);
    logic [127:0] p;
    logic [127:0] t;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (s - 1));
    t = p >> s;
    if (t[127:64] != '0) return '1;
    return t[63:0];
  endfunction

  // reciprocal of the cordic gain in q60, newton on 1/sqrt of gain squared
  function automatic logic [63:0] inv_gain_q60(input int steps);
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] py2;
    logic [63:0] t;
    p = 64'd1 << 63;
    y = 64'd691752902764108186;
    for (int i = 1; i < steps; i++) begin
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    for (int i = 0; i < 10; i++) begin
      y2  = mulshr_c(y, y, 60);
      py2 = mulshr_c(p, y2, 62);
      t   = (64'd3 << 60) - py2;
      y   = mulshr_c(y, t, 61);
    end
    return y;
  endfunction

  // 2*pi in q58 equals pi/4 in q61
  localparam logic [63:0] TWO_PI_Q58 = pi_quarter_q61();

endpackage

`default_nettype wire

// ===== design/coup_if.sv =====
// ----------------------------------------------------------------------------
// circular orbit position update: channel interfaces
// valid/ready channels for the body items and the result items
// ----------------------------------------------------------------------------
`default_nettype none

interface coup_in_if;
  import coup_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ID_W-1:0]           body_id;
  logic [ID_W-1:0]           center_id;
  logic [RADIUS_W-1:0]       orbit_radius;
  logic signed [RATE_W-1:0]  turn_rate;
  logic [START_W-1:0]        start_phase;
  logic [TIME_W-1:0]         elapsed_time;

  modport source (output valid, body_id, center_id, orbit_radius, turn_rate, start_phase,
                  elapsed_time, input ready);
  modport sink   (input valid, body_id, center_id, orbit_radius, turn_rate, start_phase,
                  elapsed_time, output ready);
endinterface

interface coup_out_if;
  import coup_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ID_W-1:0]          out_body_id;
  logic                     moved;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic signed [POS_W-1:0]  vel_x;
  logic signed [POS_W-1:0]  vel_y;

  modport source (output valid, out_body_id, moved, pos_x, pos_y, pos_z, vel_x, vel_y,
                  input ready);
  modport sink   (input valid, out_body_id, moved, pos_x, pos_y, pos_z, vel_x, vel_y,
                  output ready);
endinterface

`default_nettype wire

// ===== design/coup_mul.sv =====
// ----------------------------------------------------------------------------
// circular orbit position update: shared multiplier
// 64x64 product from four 32x32 partials, accumulator preloaded with rounding
// ----------------------------------------------------------------------------
`default_nettype none

module coup_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  input  logic [127:0] rnd_i,
  output logic [127:0] prod_o,
  output logic         done_o
);
  logic [63:0]  a_q, b_q;
  logic [127:0] acc_q;
  logic [63:0]  pp_q;
  logic [1:0]   psh_q;
  logic [1:0]   cnt_q;
  logic         busy_q, pv_q, pl_q, done_q;
  logic [31:0]  a_h, b_h;
  logic [1:0]   sh;
  logic [127:0] addend;

  // half selection for the current partial
  always_comb begin
    a_h = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    b_h = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    sh  = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
  end

  // align the registered partial
  always_comb begin
    case (psh_q)
      2'd0:    addend = {64'd0, pp_q};
      2'd1:    addend = {32'd0, pp_q, 32'd0};
      default: addend = {pp_q, 64'd0};
    endcase
  end

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      pv_q   <= 1'b0;
      pl_q   <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      pv_q   <= 1'b0;
      pl_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      pv_q   <= busy_q;
      pl_q   <= busy_q && (cnt_q == 2'd3);
      done_q <= pv_q && pl_q;
      if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) busy_q <= 1'b0;
      end
    end
  end

  // operands, partial product and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= rnd_i;
    end else begin
      if (busy_q) begin
        pp_q  <= {32'd0, a_h} * {32'd0, b_h};
        psh_q <= sh;
      end
      if (pv_q) acc_q <= acc_q + addend;
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;
endmodule

`default_nettype wire

// ===== design/coup_store.sv =====
// ----------------------------------------------------------------------------
// circular orbit position update: position table
// one write port, two registered read ports, valid bit per slot
// ----------------------------------------------------------------------------
`default_nettype none

module coup_store #(
  parameter int NUM_BODIES = coup_pkg::NUM_BODIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [$clog2(NUM_BODIES)-1:0] ra_i,
  input  logic [$clog2(NUM_BODIES)-1:0] rb_i,
  input  logic                          we_i,
  input  logic [$clog2(NUM_BODIES)-1:0] wa_i,
  input  coup_pkg::pos_t                wd_i,
  output coup_pkg::pos_t                rda_o,
  output coup_pkg::pos_t                rdb_o
);
  import coup_pkg::*;

  pos_t                  mem_q [NUM_BODIES];
  pos_t                  rda_q, rdb_q;
  logic [NUM_BODIES-1:0] valid_q;
  logic                  va_q, vb_q;

  // storage and read data
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[wa_i] <= wd_i;
    if (rd_en_i) begin
      rda_q <= mem_q[ra_i];
      rdb_q <= mem_q[rb_i];
    end
  end

  // slot valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
    end else begin
      if (we_i) valid_q[wa_i] <= 1'b1;
      if (rd_en_i) begin
        va_q <= valid_q[ra_i];
        vb_q <= valid_q[rb_i];
      end
    end
  end

  // an unwritten slot reads as zero
  assign rda_o = va_q ? rda_q : '0;
  assign rdb_o = vb_q ? rdb_q : '0;
endmodule

`default_nettype wire

// ===== design/coup_dp.sv =====
// ----------------------------------------------------------------------------
// circular orbit position update: datapath
// phase, cordic rotation, position and velocity products, result register
// ----------------------------------------------------------------------------
`default_nettype none

module coup_dp #(
  parameter int NUM_BODIES   = coup_pkg::NUM_BODIES_DEF,
  parameter int CORDIC_STEPS = coup_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  coup_pkg::coup_cmd_t                  cmd_i,
  output coup_pkg::coup_sts_t                  sts_o,
  input  logic [coup_pkg::ID_W-1:0]            body_id_i,
  input  logic [coup_pkg::ID_W-1:0]            center_id_i,
  input  logic [coup_pkg::RADIUS_W-1:0]        orbit_radius_i,
  input  logic signed [coup_pkg::RATE_W-1:0]   turn_rate_i,
  input  logic [coup_pkg::START_W-1:0]         start_phase_i,
  input  logic [coup_pkg::TIME_W-1:0]          elapsed_time_i,
  output logic [coup_pkg::ID_W-1:0]            out_body_id_o,
  output logic                                 moved_o,
  output logic signed [coup_pkg::POS_W-1:0]    pos_x_o,
  output logic signed [coup_pkg::POS_W-1:0]    pos_y_o,
  output logic signed [coup_pkg::POS_W-1:0]    pos_z_o,
  output logic signed [coup_pkg::POS_W-1:0]    vel_x_o,
  output logic signed [coup_pkg::POS_W-1:0]    vel_y_o
);
  import coup_pkg::*;

  localparam int          IdxW    = $clog2(NUM_BODIES);
  localparam int          StepW   = $clog2(CORDIC_STEPS);
  localparam logic [8:0]  NumB9   = 9'(NUM_BODIES);
  localparam logic [63:0] InvGain = inv_gain_q60(CORDIC_STEPS);

  // arctangent table
  logic [63:0] atan_rom [CORDIC_STEPS];
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_atan
    localparam logic [63:0] AtanVal = atan_q61(g);
    assign atan_rom[g] = AtanVal;
  end

  // item registers
  logic [ID_W-1:0]          body_q, center_q;
  logic [RADIUS_W-1:0]      radius_q;
  logic signed [RATE_W-1:0] rate_q;
  logic [START_W-1:0]       start_q;
  logic [TIME_W-1:0]        elapsed_q;

  // working registers
  pos_t                     ctr_q;
  logic signed [POS_W-1:0]  px_q, py_q, pz_q, vx_q, vy_q;
  logic                     moved_q;
  logic [1:0]               quad_q;
  logic [37:0]              res_q;
  logic signed [63:0]       x_q, y_q, z_q;
  logic [63:0]              omega_q, w_q;
  logic [StepW-1:0]         iter_q;

  // result register
  logic [ID_W-1:0]          ob_q;
  logic                     om_q;
  logic signed [POS_W-1:0]  ox_q, oy_q, oz_q, ovx_q, ovy_q;

  logic               body_ok, ctr_ok, rate_neg;
  logic [RATE_W-1:0]  rate_mag;
  logic signed [63:0] c_v, s_v;
  logic [63:0]        c_mag, s_mag;
  logic [63:0]        mul_a, mul_b, res64;
  logic [127:0]       mul_rnd, prod;
  logic               mul_done;
  logic [39:0]        phase;
  logic signed [63:0] dx, dy, atan_v;
  pos_t               st_a, st_b, wr_pos;

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [POS_W-1:0] base,
                                               input logic neg, input logic [48:0] mag);
    logic signed [50:0] term;
    logic signed [50:0] sum;
    term = signed'({2'b00, mag});
    if (neg) term = -term;
    sum = signed'({{3{base[POS_W-1]}}, base}) + term;
    if (sum[50:47] != 4'b0000 && sum[50:47] != 4'b1111) return sum[50] ? POS_MIN : POS_MAX;
    return sum[47:0];
  endfunction

  function automatic logic [POS_W-1:0] vel_sat(input logic [63:0] v, input logic neg);
    logic [63:0] n;
    n = -v;
    if (neg) return (v > 64'h0000_8000_0000_0000) ? POS_MIN : n[47:0];
    return (v > 64'h0000_7FFF_FFFF_FFFF) ? POS_MAX : v[47:0];
  endfunction

  // range checks and rate magnitude
  always_comb begin
    body_ok  = 9'(body_q) < NumB9;
    ctr_ok   = 9'(center_q) < NumB9;
    rate_neg = rate_q[RATE_W-1];
    rate_mag = rate_neg ? RATE_W'(-rate_q) : RATE_W'(rate_q);
  end

  // quadrant fold of the rotated vector
  always_comb begin
    case (quad_q)
      2'd0: begin c_v = x_q;  s_v = y_q;  end
      2'd1: begin c_v = -y_q; s_v = x_q;  end
      2'd2: begin c_v = -x_q; s_v = -y_q; end
      default: begin c_v = y_q; s_v = -x_q; end
    endcase
    c_mag = c_v[63] ? 64'(-c_v) : 64'(c_v);
    s_mag = s_v[63] ? 64'(-s_v) : 64'(s_v);
  end

  // multiplier operands and rounding preload
  always_comb begin
    case (cmd_i.op)
      MOP_PHASE: begin
        mul_a = {{(64-RATE_W){rate_q[RATE_W-1]}}, rate_q};
        mul_b = 64'(elapsed_q);  mul_rnd = '0;
      end
      MOP_ANGLE: begin mul_a = 64'(res_q);    mul_b = TWO_PI_Q58; mul_rnd = '0;           end
      MOP_POSX:  begin mul_a = 64'(radius_q); mul_b = c_mag;      mul_rnd = 128'd1 << 59; end
      MOP_POSY:  begin mul_a = 64'(radius_q); mul_b = s_mag;      mul_rnd = 128'd1 << 59; end
      MOP_OMEGA: begin mul_a = 64'(rate_mag); mul_b = TWO_PI_Q58; mul_rnd = 128'd1 << 37; end
      MOP_WX:    begin mul_a = omega_q;       mul_b = s_mag;      mul_rnd = 128'd1 << 59; end
      MOP_WY:    begin mul_a = omega_q;       mul_b = c_mag;      mul_rnd = 128'd1 << 59; end
      MOP_VX, MOP_VY: begin
        mul_a = 64'(radius_q); mul_b = w_q; mul_rnd = 128'd1 << 51;
      end
      default:   begin mul_a = '0; mul_b = '0; mul_rnd = '0; end
    endcase
  end

  coup_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .rnd_i   (mul_rnd),
    .prod_o  (prod),
    .done_o  (mul_done)
  );

  // product scaling, with a clamp on the position, rate and velocity products
  always_comb begin
    phase = prod[55:16] + {start_q, 8'd0};
    case (cmd_i.op)
      MOP_ANGLE: res64 = prod[100:37];
      MOP_OMEGA: res64 = (prod[127:102] != '0) ? '1 : prod[101:38];
      MOP_VX, MOP_VY: res64 = (prod[127:116] != '0) ? '1 : prod[115:52];
      MOP_POSX, MOP_POSY, MOP_WX, MOP_WY: res64 = (prod[127:124] != '0) ? '1 : prod[123:60];
      default:   res64 = '0;
    endcase
  end

  // cordic micro-rotation terms
  always_comb begin
    dx     = y_q >>> iter_q;
    dy     = x_q >>> iter_q;
    atan_v = signed'(atan_rom[iter_q]);
  end

  assign wr_pos = '{x: px_q, y: py_q, z: pz_q};

  coup_store #(.NUM_BODIES(NUM_BODIES)) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (cmd_i.accept),
    .ra_i    (IdxW'(center_id_i)),
    .rb_i    (IdxW'(body_id_i)),
    .we_i    (cmd_i.finish && body_ok),
    .wa_i    (IdxW'(body_q)),
    .wd_i    (wr_pos),
    .rda_o   (st_a),
    .rdb_o   (st_b)
  );

  // iteration counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else if (cmd_i.capture && cmd_i.op == MOP_ANGLE) begin
      iter_q <= '0;
    end else if (cmd_i.rot_step) begin
      iter_q <= iter_q + StepW'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      body_q    <= body_id_i;
      center_q  <= center_id_i;
      radius_q  <= orbit_radius_i;
      rate_q    <= turn_rate_i;
      start_q   <= start_phase_i;
      elapsed_q <= elapsed_time_i;
    end
    // table data: centre, or own slot for a fixed body
    if (cmd_i.load) begin
      ctr_q   <= ctr_ok ? st_a : '0;
      px_q    <= body_ok ? st_b.x : '0;
      py_q    <= body_ok ? st_b.y : '0;
      if (radius_q == '0) pz_q <= body_ok ? st_b.z : '0;
      else pz_q <= ctr_ok ? st_a.z : '0;
      vx_q    <= '0;
      vy_q    <= '0;
      moved_q <= (radius_q != '0);
    end
    if (cmd_i.capture) begin
      case (cmd_i.op)
        MOP_PHASE: begin
          quad_q <= phase[39:38];
          res_q  <= phase[37:0];
        end
        MOP_ANGLE: begin
          z_q <= signed'(res64);
          x_q <= signed'(InvGain);
          y_q <= '0;
        end
        MOP_POSX:  px_q    <= sat_pos(ctr_q.x, c_v[63], res64[48:0]);
        MOP_POSY:  py_q    <= sat_pos(ctr_q.y, s_v[63], res64[48:0]);
        MOP_OMEGA: omega_q <= res64;
        MOP_WX:    w_q     <= res64;
        MOP_WY:    w_q     <= res64;
        MOP_VX:    vx_q    <= vel_sat(res64, rate_neg == s_v[63]);
        MOP_VY:    vy_q    <= vel_sat(res64, rate_neg != c_v[63]);
        default: ;
      endcase
    end
    if (cmd_i.rot_step) begin
      if (!z_q[63]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_v;
      end
    end
    if (cmd_i.finish) begin
      ob_q  <= body_q;
      om_q  <= moved_q;
      ox_q  <= px_q;
      oy_q  <= py_q;
      oz_q  <= pz_q;
      ovx_q <= vx_q;
      ovy_q <= vy_q;
    end
  end

  assign sts_o = '{radius_zero: (radius_q == '0), mul_done: mul_done,
                   rot_last: (iter_q == StepW'(CORDIC_STEPS - 1))};

  assign out_body_id_o = ob_q;
  assign moved_o       = om_q;
  assign pos_x_o       = ox_q;
  assign pos_y_o       = oy_q;
  assign pos_z_o       = oz_q;
  assign vel_x_o       = ovx_q;
  assign vel_y_o       = ovy_q;
endmodule

`default_nettype wire

// ===== design/coup_ctrl.sv =====
// ----------------------------------------------------------------------------
// circular orbit position update: controller
// sequences table read, nine products, cordic rotation and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module coup_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output coup_pkg::coup_cmd_t cmd_o,
  input  coup_pkg::coup_sts_t sts_i
);
  import coup_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ISSUE,
    S_MUL,
    S_ROT,
    S_FIN
  } state_e;

  state_e  state_q;
  mul_op_e op_q;
  logic    out_valid_q;

  function automatic mul_op_e next_op(input mul_op_e op);
    case (op)
      MOP_PHASE: return MOP_ANGLE;
      MOP_POSX:  return MOP_POSY;
      MOP_POSY:  return MOP_OMEGA;
      MOP_OMEGA: return MOP_WX;
      MOP_WX:    return MOP_VX;
      MOP_VX:    return MOP_WY;
      MOP_WY:    return MOP_VY;
      default:   return MOP_PHASE;
    endcase
  endfunction

  // commands from the current state
  always_comb begin
    cmd_o    = '0;
    cmd_o.op = op_q;
    case (state_q)
      S_IDLE:  cmd_o.accept    = in_valid_i;
      S_LOAD:  cmd_o.load      = 1'b1;
      S_ISSUE: cmd_o.mul_start = 1'b1;
      S_MUL:   cmd_o.capture   = sts_i.mul_done;
      S_ROT:   cmd_o.rot_step  = 1'b1;
      S_FIN:   cmd_o.finish    = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= MOP_PHASE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_LOAD;
        S_LOAD: begin
          op_q <= MOP_PHASE;
          state_q <= sts_i.radius_zero ? S_FIN : S_ISSUE;
        end
        S_ISSUE: state_q <= S_MUL;
        S_MUL: begin
          if (sts_i.mul_done) begin
            case (op_q)
              MOP_ANGLE: state_q <= S_ROT;
              MOP_VY:    state_q <= S_FIN;
              default: begin
                op_q    <= next_op(op_q);
                state_q <= S_ISSUE;
              end
            endcase
          end
        end
        S_ROT: begin
          if (sts_i.rot_last) begin
            op_q    <= MOP_POSX;
            state_q <= S_ISSUE;
          end
        end
        S_FIN: if (cmd_o.finish) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

`default_nettype wire

// ===== design/circular_orbit_position_update.sv =====
// ----------------------------------------------------------------------------
// circular orbit position update: top level
// moves one body one tick along a circular orbit around a stored centre body
// ----------------------------------------------------------------------------
// One body is processed at a time. A moving body goes from acceptance to its
// result through the table read, nine products through the single 32x32
// multiplier, the CORDIC rotation at one step per cycle and the load of the
// output register; a zero-radius body goes from the table read straight to
// the output register. The next body is accepted once the previous result
// has been moved into the output register, even while that result is still
// waiting to be taken. Positions are kept per slot in a table with a valid
// bit per slot, so no clearing pass is needed after reset; unwritten slots
// read as zero and an absent centre is the origin.
`default_nettype none

module circular_orbit_position_update #(
  parameter int NUM_BODIES   = coup_pkg::NUM_BODIES_DEF,
  parameter int CORDIC_STEPS = coup_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  coup_in_if.sink           in_i,
  coup_out_if.source        out_o
);
  import coup_pkg::*;

  `include "circular_orbit_position_update_assert.svh"

  coup_cmd_t cmd;
  coup_sts_t sts;

  coup_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  coup_dp #(
    .NUM_BODIES   (NUM_BODIES),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .body_id_i      (in_i.body_id),
    .center_id_i    (in_i.center_id),
    .orbit_radius_i (in_i.orbit_radius),
    .turn_rate_i    (in_i.turn_rate),
    .start_phase_i  (in_i.start_phase),
    .elapsed_time_i (in_i.elapsed_time),
    .out_body_id_o  (out_o.out_body_id),
    .moved_o        (out_o.moved),
    .pos_x_o        (out_o.pos_x),
    .pos_y_o        (out_o.pos_y),
    .pos_z_o        (out_o.pos_z),
    .vel_x_o        (out_o.vel_x),
    .vel_y_o        (out_o.vel_y)
  );

  // checks
  `COUP_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready,
                    !in_i.ready, "item accepted while previous still in work")
  `COUP_ASSERT_SAME(a_finish_slot_free, clk_i, rst_ni, cmd.finish,
                    !out_o.valid || out_o.ready, "result overwrites an untaken item")
  `COUP_ASSERT_SAME(a_valid_from_finish, clk_i, rst_ni, $rose(out_o.valid),
                    $past(cmd.finish), "result valid without a finished item")
  `COUP_ASSERT_SAME(a_fixed_no_vel, clk_i, rst_ni, out_o.valid && !out_o.moved,
                    out_o.vel_x == '0 && out_o.vel_y == '0, "fixed body with velocity")
endmodule

`default_nettype wire
